### sv/udp_frame_receive_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// UDP frame receive filter assertion macros
// Shared concurrent assertion forms used by the filter top level.
// ----------------------------------------------------------------------------
`ifndef UDP_FRAME_RECEIVE_FILTER_UNIT_MACROS_SVH
`define UDP_FRAME_RECEIVE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UFRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/udp_frf_pkg.sv
// ----------------------------------------------------------------------------
// UDP frame receive filter package
// Shared widths, protocol constants, reason codes and the result type.
// ----------------------------------------------------------------------------
package udp_frf_pkg;

    localparam int MAX_FRAME = 2048;
    localparam int OFFSET_W  = $clog2(MAX_FRAME + 1);
    // wide enough for header position plus a full UDP length
    localparam int SUM_W     = 17;

    localparam logic [SUM_W-1:0] MAX_FRAME_S   = SUM_W'(MAX_FRAME);
    localparam logic [SUM_W-1:0] OFS_TYPE_HI   = SUM_W'(12);
    localparam logic [SUM_W-1:0] OFS_TYPE_LO   = SUM_W'(13);
    localparam logic [SUM_W-1:0] OFS_IHL       = SUM_W'(14);
    localparam logic [SUM_W-1:0] OFS_PROTO     = SUM_W'(23);
    localparam logic [SUM_W-1:0] LEN_ETH_HDR   = SUM_W'(14);
    localparam logic [SUM_W-1:0] LEN_IHL_BYTE  = SUM_W'(15);
    localparam logic [SUM_W-1:0] LEN_MIN_IP    = SUM_W'(24);
    localparam logic [SUM_W-1:0] UDP_HDR_BYTES = SUM_W'(8);

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [3:0]  MIN_HDR_WORDS    = 4'd5;
    localparam logic [15:0] UDP_MIN_LEN      = 16'd8;
    localparam logic [15:0] LOCAL_PORT_RESET = 16'd9999;

    localparam logic [2:0] REASON_OK        = 3'd0;
    localparam logic [2:0] REASON_NOT_IPV4  = 3'd1;
    localparam logic [2:0] REASON_NOT_UDP   = 3'd2;
    localparam logic [2:0] REASON_PORT      = 3'd3;
    localparam logic [2:0] REASON_TRUNCATED = 3'd4;
    localparam logic [2:0] REASON_BAD_LEN   = 3'd5;

    localparam int           PADDR_W        = 3;
    localparam logic [0:0]   CFG_LOCAL_PORT = 1'b0;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        is_payload;
        logic        frame_end;
        logic        accepted;
        logic [15:0] data_len;
        logic [2:0]  reject_reason;
    } result_t;

    typedef struct packed {
        logic frame_start;
    } parse_status_t;

endpackage

### sv/udp_frf_chan_if.sv
// ----------------------------------------------------------------------------
// UDP frame receive filter channels
// Valid/ready byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface udp_frf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_last;

    modport source (output valid, output data_byte, output frame_last, input ready);
    modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface udp_frf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic        is_payload;
    logic        frame_end;
    logic        accepted;
    logic [15:0] data_len;
    logic [2:0]  reject_reason;

    modport source (output valid, output byte_out, output is_payload, output frame_end,
                    output accepted, output data_len, output reject_reason,
                    input ready);
    modport sink   (input valid, input byte_out, input is_payload, input frame_end,
                    input accepted, input data_len, input reject_reason,
                    output ready);
endinterface

### sv/udp_frf_parser.sv
// ----------------------------------------------------------------------------
// UDP frame receive filter header parser
// Tracks the byte offset, captures header fields and judges each frame.
// ----------------------------------------------------------------------------
module udp_frf_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [7:0]               data_byte,
    input  logic                     frame_last,
    input  logic [15:0]              local_port,
    output udp_frf_pkg::result_t     result,
    output udp_frf_pkg::parse_status_t status
);

    logic [udp_frf_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ip_protocol_reg, ip_protocol_next;
    logic [15:0] dest_port_reg, dest_port_next;
    logic [15:0] udp_length_reg, udp_length_next;

    logic [udp_frf_pkg::SUM_W-1:0] pos;
    logic [udp_frf_pkg::SUM_W-1:0] udp_pos;
    logic [udp_frf_pkg::SUM_W-1:0] udp_end;
    logic [udp_frf_pkg::SUM_W-1:0] len;
    logic                          in_bound;
    logic                          hdr_match;
    logic [2:0]                    reason;

    always_comb
    begin
        pos      = udp_frf_pkg::SUM_W'(offset_reg);
        in_bound = (pos < udp_frf_pkg::MAX_FRAME_S);

        ether_type_next   = ether_type_reg;
        header_words_next = header_words_reg;
        ip_protocol_next  = ip_protocol_reg;
        dest_port_next    = dest_port_reg;
        udp_length_next   = udp_length_reg;

        // capture fixed-position Ethernet and IPv4 fields
        if (in_bound)
        begin
            if (pos == udp_frf_pkg::OFS_TYPE_HI)
                ether_type_next = {data_byte, ether_type_reg[7:0]};
            else if (pos == udp_frf_pkg::OFS_TYPE_LO)
                ether_type_next = {ether_type_reg[15:8], data_byte};
            else if (pos == udp_frf_pkg::OFS_IHL)
                header_words_next = data_byte[3:0];
            else if (pos == udp_frf_pkg::OFS_PROTO)
                ip_protocol_next = data_byte;
        end

        // UDP header starts after the Ethernet and IPv4 headers
        udp_pos = udp_frf_pkg::LEN_ETH_HDR
                + udp_frf_pkg::SUM_W'({header_words_next, 2'b00});

        if (in_bound)
        begin
            if (pos == udp_pos + udp_frf_pkg::SUM_W'(2))
                dest_port_next = {data_byte, dest_port_reg[7:0]};
            else if (pos == udp_pos + udp_frf_pkg::SUM_W'(3))
                dest_port_next = {dest_port_reg[15:8], data_byte};
            else if (pos == udp_pos + udp_frf_pkg::SUM_W'(4))
                udp_length_next = {data_byte, udp_length_reg[7:0]};
            else if (pos == udp_pos + udp_frf_pkg::SUM_W'(5))
                udp_length_next = {udp_length_reg[15:8], data_byte};
        end

        udp_end   = udp_pos + udp_frf_pkg::SUM_W'(udp_length_next);
        hdr_match = (ether_type_next == udp_frf_pkg::ETHERTYPE_IPV4)
                 && (header_words_next >= udp_frf_pkg::MIN_HDR_WORDS)
                 && (ip_protocol_next == udp_frf_pkg::PROTO_UDP)
                 && (dest_port_next == local_port)
                 && (udp_length_next >= udp_frf_pkg::UDP_MIN_LEN);

        // saturate the offset at the frame bound
        len = in_bound ? pos + udp_frf_pkg::SUM_W'(1) : pos;

        if (len < udp_frf_pkg::LEN_ETH_HDR)
            reason = udp_frf_pkg::REASON_TRUNCATED;
        else if (ether_type_next != udp_frf_pkg::ETHERTYPE_IPV4)
            reason = udp_frf_pkg::REASON_NOT_IPV4;
        else if (len < udp_frf_pkg::LEN_IHL_BYTE)
            reason = udp_frf_pkg::REASON_TRUNCATED;
        else if (header_words_next < udp_frf_pkg::MIN_HDR_WORDS)
            reason = udp_frf_pkg::REASON_BAD_LEN;
        else if (len < udp_frf_pkg::LEN_MIN_IP)
            reason = udp_frf_pkg::REASON_TRUNCATED;
        else if (ip_protocol_next != udp_frf_pkg::PROTO_UDP)
            reason = udp_frf_pkg::REASON_NOT_UDP;
        else if (len < udp_pos + udp_frf_pkg::UDP_HDR_BYTES)
            reason = udp_frf_pkg::REASON_TRUNCATED;
        else if (dest_port_next != local_port)
            reason = udp_frf_pkg::REASON_PORT;
        else if (udp_length_next < udp_frf_pkg::UDP_MIN_LEN)
            reason = udp_frf_pkg::REASON_BAD_LEN;
        else if (len < udp_end)
            reason = udp_frf_pkg::REASON_TRUNCATED;
        else
            reason = udp_frf_pkg::REASON_OK;

        result.byte_out   = data_byte;
        result.is_payload = in_bound && hdr_match
                         && (pos >= udp_pos + udp_frf_pkg::UDP_HDR_BYTES)
                         && (pos < udp_end);
        result.frame_end  = frame_last;
        if (frame_last)
        begin
            result.accepted      = (reason == udp_frf_pkg::REASON_OK);
            result.reject_reason = reason;
            result.data_len      = (reason == udp_frf_pkg::REASON_OK)
                                 ? udp_length_next - udp_frf_pkg::UDP_MIN_LEN : 16'd0;
        end
        else
        begin
            result.accepted      = 1'b0;
            result.reject_reason = udp_frf_pkg::REASON_OK;
            result.data_len      = 16'd0;
        end

        offset_next = in_bound ? offset_reg + udp_frf_pkg::OFFSET_W'(1) : offset_reg;

        status.frame_start = (offset_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            ip_protocol_reg  <= '0;
            dest_port_reg    <= '0;
            udp_length_reg   <= '0;
        end
        else if (fire)
        begin
            if (frame_last)
            begin
                // clear for the next frame
                offset_reg       <= '0;
                ether_type_reg   <= '0;
                header_words_reg <= '0;
                ip_protocol_reg  <= '0;
                dest_port_reg    <= '0;
                udp_length_reg   <= '0;
            end
            else
            begin
                offset_reg       <= offset_next;
                ether_type_reg   <= ether_type_next;
                header_words_reg <= header_words_next;
                ip_protocol_reg  <= ip_protocol_next;
                dest_port_reg    <= dest_port_next;
                udp_length_reg   <= udp_length_next;
            end
        end
    end

endmodule

### sv/udp_frame_receive_filter_unit.sv
// ----------------------------------------------------------------------------
// UDP frame receive filter
// Ethernet/IPv4/UDP destination port filter on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one frame byte per transfer in wire order, with
//   frame_last high on the final byte. out_chan returns one result per
//   input byte: the byte itself, a payload flag for bytes of a matching
//   frame, and on the final byte the verdict, reject reason and payload
//   length.
//   The APB port holds local_port at byte address 0 (reset value 9999);
//   write it only while no frame is in flight.
//   A byte accepted on in_chan is registered and shows on out_chan in the
//   next cycle. Throughput is one byte per cycle while the receiver takes
//   each result, set by the single result register; the header parser
//   decides each byte in one combinational pass.
//   When the receiver stalls, the result register holds and in_chan.ready
//   drops until the result is taken; the next byte moves in the same cycle
//   the pending result leaves.
//   Reset clears the frame state, drops out_chan.valid and restores
//   local_port to its reset value.
// ----------------------------------------------------------------------------
`include "udp_frame_receive_filter_unit_macros.svh"

module udp_frame_receive_filter_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    udp_frf_in_if.sink                        in_chan,
    udp_frf_out_if.source                     out_chan,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [udp_frf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [15:0]                local_port_reg;
    logic                       cfg_write;
    logic [0:0]                 cfg_index;

    logic                       in_fire;
    logic                       out_valid_reg;
    udp_frf_pkg::result_t       out_res_reg;
    udp_frf_pkg::result_t       parse_res;
    udp_frf_pkg::parse_status_t parse_status;

    // ------------------------------------------------------------------
    // Configuration port: one register, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[udp_frf_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            udp_frf_pkg::CFG_LOCAL_PORT: prdata = {16'd0, local_port_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_port_reg <= udp_frf_pkg::LOCAL_PORT_RESET;
        else if (cfg_write && (cfg_index == udp_frf_pkg::CFG_LOCAL_PORT))
            local_port_reg <= pwdata[15:0];
    end

    // ------------------------------------------------------------------
    // Input handshake: take a byte whenever the result register is free
    // or being drained in this cycle
    // ------------------------------------------------------------------
    assign in_chan.ready = !out_valid_reg || out_chan.ready;
    assign in_fire       = in_chan.valid && in_chan.ready;

    udp_frf_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .data_byte  (in_chan.data_byte),
        .frame_last (in_chan.frame_last),
        .local_port (local_port_reg),
        .result     (parse_res),
        .status     (parse_status)
    );

    // ------------------------------------------------------------------
    // Result register: load on every input transfer, hold while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_chan.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_res_reg <= parse_res;
    end

    assign out_chan.valid         = out_valid_reg;
    assign out_chan.byte_out      = out_res_reg.byte_out;
    assign out_chan.is_payload    = out_res_reg.is_payload;
    assign out_chan.frame_end     = out_res_reg.frame_end;
    assign out_chan.accepted      = out_res_reg.accepted;
    assign out_chan.data_len      = out_res_reg.data_len;
    assign out_chan.reject_reason = out_res_reg.reject_reason;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // A last byte transfer must leave a frame-end result and rewind the parser.
    `UFRF_ASSERT_NEXT(a_last_to_end, clk, rst_n, in_fire && in_chan.frame_last, out_chan.valid && out_chan.frame_end && parse_status.frame_start, "last byte did not close the frame")
    // Input back-pressure only comes from a pending, untaken result.
    `UFRF_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_chan.ready, out_chan.valid && !out_chan.ready, "input stalled without a pending result")
    // A verdict of accept carries reason ok and never shows mid-frame.
    `UFRF_ASSERT_NOW(a_accept_ok, clk, rst_n, out_chan.valid && out_chan.accepted, out_chan.frame_end && (out_chan.reject_reason == udp_frf_pkg::REASON_OK), "accept without frame end or with a reject code")

endmodule
